// ===== rtl/bis_pkg.sv =====
// Shared types and constants of the bilinear image scaler.
`timescale 1ns / 1ps
package bis_pkg;

    // Field widths fixed by the interface
    localparam int CMD_W      = 1;
    localparam int LOAD_W     = 9;
    localparam int DEST_W     = 14;
    localparam int SCALE_W    = 20;
    localparam int SIZE_W     = 10;
    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 3;
    localparam int PIX_W      = CHAN_W * NUM_CHAN;
    localparam int PROD_W     = DEST_W + SCALE_W;
    localparam int NUM_BANKS  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // Register reset values
    localparam logic [SCALE_W-1:0] SCALE_RESET = 20'd65536;
    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 10'd512;
    localparam logic [CHAN_W-1:0]  CHAN_MAX    = 8'hFF;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INV_SCALE_X   = 2'd0,
        REG_INV_SCALE_Y   = 2'd1,
        REG_SOURCE_WIDTH  = 2'd2,
        REG_SOURCE_HEIGHT = 2'd3
    } cfg_reg_t;

    // Query control handed from the address stage to the blend pipeline
    typedef struct packed {
        logic valid;
        logic in_range;
        logic par_x;
        logic par_y;
    } query_ctrl_t;

endpackage

// ===== rtl/bis_bank.sv =====
// One parity bank of the frame store: single-port synchronous RAM.
`timescale 1ns / 1ps
module bis_bank #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16,
    parameter int DATA_W = 24
) (
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // write or registered read, one access per cycle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bis_map.sv =====
// Coordinate mapping, bounds check and bank address generation.
`timescale 1ns / 1ps
module bis_map #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int FRAC_BITS  = 16,
    parameter int ADDR_W     = 16
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          accept,
    input  logic                                          command,
    input  logic [bis_pkg::LOAD_W-1:0]                    load_col,
    input  logic [bis_pkg::LOAD_W-1:0]                    load_row,
    input  logic [bis_pkg::PIX_W-1:0]                     load_pix,
    input  logic [bis_pkg::DEST_W-1:0]                    dest_col,
    input  logic [bis_pkg::DEST_W-1:0]                    dest_row,
    input  logic [bis_pkg::SCALE_W-1:0]                   inv_scale_x,
    input  logic [bis_pkg::SCALE_W-1:0]                   inv_scale_y,
    input  logic [bis_pkg::SIZE_W-1:0]                    source_width,
    input  logic [bis_pkg::SIZE_W-1:0]                    source_height,
    output logic [bis_pkg::NUM_BANKS-1:0]                 bank_en,
    output logic [bis_pkg::NUM_BANKS-1:0]                 bank_we,
    output logic [bis_pkg::NUM_BANKS-1:0][ADDR_W-1:0]     bank_addr,
    output logic [bis_pkg::PIX_W-1:0]                     bank_wdata,
    output bis_pkg::query_ctrl_t                          ctrl,
    output logic [FRAC_BITS-1:0]                          frac_x,
    output logic [FRAC_BITS-1:0]                          frac_y
);
    import bis_pkg::*;

    localparam int HALF_W = (MAX_WIDTH + 1) / 2;
    localparam int HALF_H = (MAX_HEIGHT + 1) / 2;
    localparam int HC_W   = (HALF_W > 1) ? $clog2(HALF_W) : 1;
    localparam int HR_W   = (HALF_H > 1) ? $clog2(HALF_H) : 1;
    localparam int PX_W   = PROD_W - FRAC_BITS;

    // stage 1 registers
    logic                valid1_reg;
    logic                query1_reg;
    logic [LOAD_W-1:0]   col1_reg;
    logic [LOAD_W-1:0]   row1_reg;
    logic [PIX_W-1:0]    pix1_reg;
    logic [PROD_W-1:0]   sx1_reg;
    logic [PROD_W-1:0]   sy1_reg;

    // stage 2 registers
    query_ctrl_t          ctrl_reg;
    query_ctrl_t          ctrl_next;
    logic [FRAC_BITS-1:0] fx_reg;
    logic [FRAC_BITS-1:0] fy_reg;

    // stage 1 combinational
    logic [PX_W-1:0]      px;
    logic [PX_W-1:0]      py;
    logic [PX_W:0]        px_inc;
    logic [PX_W:0]        py_inc;
    logic                 in_range;
    logic [HC_W-1:0]      qcol_base;
    logic [HR_W-1:0]      qrow_base;
    logic [HC_W-1:0]      lcol;
    logic [HR_W-1:0]      lrow;
    logic                 load_ok;
    logic [HC_W-1:0]      hc;
    logic [HR_W-1:0]      hr;

    // accept stage: scale multiply and load capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            query1_reg <= (command == CMD_QUERY);
            col1_reg   <= load_col;
            row1_reg   <= load_row;
            pix1_reg   <= load_pix;
            sx1_reg    <= PROD_W'(dest_col) * PROD_W'(inv_scale_x);
            sy1_reg    <= PROD_W'(dest_row) * PROD_W'(inv_scale_y);
        end
    end

    // base, fraction, bounds and per-bank addresses
    always_comb
    begin
        px        = sx1_reg[PROD_W-1:FRAC_BITS];
        py        = sy1_reg[PROD_W-1:FRAC_BITS];
        px_inc    = {1'b0, px} + (PX_W+1)'(1);
        py_inc    = {1'b0, py} + (PX_W+1)'(1);
        in_range  = (px_inc < (PX_W+1)'(source_width)) &&
                    (px_inc < (PX_W+1)'(MAX_WIDTH)) &&
                    (py_inc < (PX_W+1)'(source_height)) &&
                    (py_inc < (PX_W+1)'(MAX_HEIGHT));
        qcol_base = px[HC_W:1];
        qrow_base = py[HR_W:1];
        lcol      = HC_W'(col1_reg >> 1);
        lrow      = HR_W'(row1_reg >> 1);
        load_ok   = (32'(col1_reg) < 32'(MAX_WIDTH)) && (32'(row1_reg) < 32'(MAX_HEIGHT));
        hc        = '0;
        hr        = '0;
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            if (query1_reg)
            begin
                // even-parity bank takes the next column or row when base is odd
                hc = (b[0] == 1'b0) ? qcol_base + HC_W'(px[0]) : qcol_base;
                hr = (b[1] == 1'b0) ? qrow_base + HR_W'(py[0]) : qrow_base;
                bank_en[b] = valid1_reg;
                bank_we[b] = 1'b0;
            end
            else
            begin
                hc = lcol;
                hr = lrow;
                bank_en[b] = valid1_reg && load_ok &&
                             (col1_reg[0] == b[0]) && (row1_reg[0] == b[1]);
                bank_we[b] = 1'b1;
            end
            bank_addr[b] = ADDR_W'(hr * HALF_W) + ADDR_W'(hc);
        end
        bank_wdata = pix1_reg;

        ctrl_next.valid    = valid1_reg && query1_reg;
        ctrl_next.in_range = in_range;
        ctrl_next.par_x    = px[0];
        ctrl_next.par_y    = py[0];
    end

    // control aligned with the bank read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fx_reg <= sx1_reg[FRAC_BITS-1:0];
        fy_reg <= sy1_reg[FRAC_BITS-1:0];
    end

    assign ctrl   = ctrl_reg;
    assign frac_x = fx_reg;
    assign frac_y = fy_reg;

endmodule

// ===== rtl/bis_blend.sv =====
// Weight generation, four-neighbor blend, rounding and saturation.
`timescale 1ns / 1ps
module bis_blend #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  bis_pkg::query_ctrl_t                              ctrl,
    input  logic [FRAC_BITS-1:0]                              frac_x,
    input  logic [FRAC_BITS-1:0]                              frac_y,
    input  logic [bis_pkg::NUM_BANKS-1:0][bis_pkg::PIX_W-1:0] bank_rdata,
    output logic                                              result_valid,
    output logic [bis_pkg::CHAN_W-1:0]                        out_blue,
    output logic [bis_pkg::CHAN_W-1:0]                        out_green,
    output logic [bis_pkg::CHAN_W-1:0]                        out_red,
    output logic                                              inside_res
);
    import bis_pkg::*;

    localparam int WT_W   = FRAC_BITS + 1;
    localparam int W_W    = 2 * FRAC_BITS + 1;
    localparam int ACC_W  = W_W + CHAN_W;
    localparam int SHIFT  = 2 * FRAC_BITS;
    localparam int VAL_W  = ACC_W - SHIFT;

    // weight stage
    logic [WT_W-1:0]                          one_fx;
    logic [WT_W-1:0]                          fx_e;
    logic [WT_W-1:0]                          fy_e;
    logic [WT_W-1:0]                          gx;
    logic [WT_W-1:0]                          gy;
    logic [NUM_BANKS-1:0][W_W-1:0]            wt_next;
    logic [NUM_BANKS-1:0][PIX_W-1:0]          nb_next;
    logic [NUM_BANKS-1:0][W_W-1:0]            wt3_reg;
    logic [NUM_BANKS-1:0][PIX_W-1:0]          nb3_reg;
    logic                                     valid3_reg;
    logic                                     inside3_reg;

    // product stage
    logic [NUM_CHAN-1:0][NUM_BANKS-1:0][ACC_W-1:0] term_next;
    logic [NUM_CHAN-1:0][NUM_BANKS-1:0][ACC_W-1:0] term4_reg;
    logic                                          valid4_reg;
    logic                                          inside4_reg;

    // output stage
    logic [NUM_CHAN-1:0][ACC_W-1:0]           acc;
    logic [NUM_CHAN-1:0][VAL_W-1:0]           val;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]          chan_next;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]          chan_reg;
    logic                                     result_valid_reg;
    logic                                     inside_res_reg;

    // weights and neighbor routing by base parity
    always_comb
    begin
        one_fx     = {1'b1, {FRAC_BITS{1'b0}}};
        fx_e       = {1'b0, frac_x};
        fy_e       = {1'b0, frac_y};
        gx         = one_fx - fx_e;
        gy         = one_fx - fy_e;
        wt_next[0] = W_W'(gx) * W_W'(gy);
        wt_next[1] = W_W'(fx_e) * W_W'(gy);
        wt_next[2] = W_W'(gx) * W_W'(fy_e);
        wt_next[3] = W_W'(fx_e) * W_W'(fy_e);
        nb_next[0] = bank_rdata[{ctrl.par_y, ctrl.par_x}];
        nb_next[1] = bank_rdata[{ctrl.par_y, ~ctrl.par_x}];
        nb_next[2] = bank_rdata[{~ctrl.par_y, ctrl.par_x}];
        nb_next[3] = bank_rdata[{~ctrl.par_y, ~ctrl.par_x}];
    end

    // weight times channel, one product per neighbor and channel
    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            for (int n = 0; n < NUM_BANKS; n++)
            begin
                term_next[c][n] = ACC_W'(wt3_reg[n]) * ACC_W'(nb3_reg[n][c*CHAN_W +: CHAN_W]);
            end
        end
    end

    // exact sum, round half up, saturate, force zero outside
    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            acc[c] = term4_reg[c][0] + term4_reg[c][1] + term4_reg[c][2] + term4_reg[c][3]
                     + (ACC_W'(1) << (SHIFT - 1));
            val[c] = acc[c][ACC_W-1:SHIFT];
            if (!inside4_reg)
            begin
                chan_next[c] = '0;
            end
            else if (val[c] > VAL_W'(CHAN_MAX))
            begin
                chan_next[c] = CHAN_MAX;
            end
            else
            begin
                chan_next[c] = val[c][CHAN_W-1:0];
            end
        end
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid3_reg       <= 1'b0;
            valid4_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            valid3_reg       <= ctrl.valid;
            valid4_reg       <= valid3_reg;
            result_valid_reg <= valid4_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        wt3_reg        <= wt_next;
        nb3_reg        <= nb_next;
        inside3_reg    <= ctrl.in_range;
        term4_reg      <= term_next;
        inside4_reg    <= inside3_reg;
        chan_reg       <= chan_next;
        inside_res_reg <= inside4_reg;
    end

    assign result_valid = result_valid_reg;
    assign out_blue     = chan_reg[0];
    assign out_green    = chan_reg[1];
    assign out_red      = chan_reg[2];
    assign inside_res   = inside_res_reg;

endmodule

// ===== rtl/bilinear_image_scaler_unit.sv =====
// Top level of the bilinear image scaler: configuration, frame store banks and pipeline.
`timescale 1ns / 1ps
// Takes one transaction per clock; busy never rises. A load (command 0) writes one
// pixel into the frame store and gives no result. A query (command 1) gives one
// result, strobed by result_valid for exactly one cycle, after the map and blend
// registers; the receiver must take it then, since it cannot stall the block. The rate
// is set by the frame store: four single-port banks split by row and column parity, so
// the four neighbors of a query come out in one read cycle. Results leave in the order
// of the queries. No clearing pass runs after reset. The user must write configuration
// with cfg_we while no transaction is in flight; the block does not enforce it.
module bilinear_image_scaler_unit #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int FRAC_BITS  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              command,
    input  logic [bis_pkg::LOAD_W-1:0]        load_col,
    input  logic [bis_pkg::LOAD_W-1:0]        load_row,
    input  logic [bis_pkg::CHAN_W-1:0]        load_blue,
    input  logic [bis_pkg::CHAN_W-1:0]        load_green,
    input  logic [bis_pkg::CHAN_W-1:0]        load_red,
    input  logic [bis_pkg::DEST_W-1:0]        dest_col,
    input  logic [bis_pkg::DEST_W-1:0]        dest_row,
    input  logic                              cfg_we,
    input  logic [bis_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bis_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              result_valid,
    output logic [bis_pkg::CHAN_W-1:0]        out_blue,
    output logic [bis_pkg::CHAN_W-1:0]        out_green,
    output logic [bis_pkg::CHAN_W-1:0]        out_red,
    output logic                              inside_res
);
    import bis_pkg::*;

    localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
    localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH = HALF_W * HALF_H;
    localparam int ADDR_W     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    // configuration registers
    logic [SCALE_W-1:0] inv_scale_x_reg;
    logic [SCALE_W-1:0] inv_scale_y_reg;
    logic [SIZE_W-1:0]  source_width_reg;
    logic [SIZE_W-1:0]  source_height_reg;

    logic                                  accept;
    logic [NUM_BANKS-1:0]                  bank_en;
    logic [NUM_BANKS-1:0]                  bank_we;
    logic [NUM_BANKS-1:0][ADDR_W-1:0]      bank_addr;
    logic [PIX_W-1:0]                      bank_wdata;
    logic [NUM_BANKS-1:0][PIX_W-1:0]       bank_rdata;
    query_ctrl_t                           ctrl;
    logic [FRAC_BITS-1:0]                  frac_x;
    logic [FRAC_BITS-1:0]                  frac_y;

    // the pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_scale_x_reg   <= SCALE_RESET;
            inv_scale_y_reg   <= SCALE_RESET;
            source_width_reg  <= SIZE_RESET;
            source_height_reg <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INV_SCALE_X:   inv_scale_x_reg   <= cfg_data[SCALE_W-1:0];
                REG_INV_SCALE_Y:   inv_scale_y_reg   <= cfg_data[SCALE_W-1:0];
                REG_SOURCE_WIDTH:  source_width_reg  <= cfg_data[SIZE_W-1:0];
                REG_SOURCE_HEIGHT: source_height_reg <= cfg_data[SIZE_W-1:0];
                default:           ;
            endcase
        end
    end

    // address stage
    bis_map #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS),
        .ADDR_W     (ADDR_W)
    ) u_map (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .command       (command),
        .load_col      (load_col),
        .load_row      (load_row),
        .load_pix      ({load_red, load_green, load_blue}),
        .dest_col      (dest_col),
        .dest_row      (dest_row),
        .inv_scale_x   (inv_scale_x_reg),
        .inv_scale_y   (inv_scale_y_reg),
        .source_width  (source_width_reg),
        .source_height (source_height_reg),
        .bank_en       (bank_en),
        .bank_we       (bank_we),
        .bank_addr     (bank_addr),
        .bank_wdata    (bank_wdata),
        .ctrl          (ctrl),
        .frac_x        (frac_x),
        .frac_y        (frac_y)
    );

    // frame store: one bank per row and column parity
    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        bis_bank #(
            .DEPTH  (BANK_DEPTH),
            .ADDR_W (ADDR_W),
            .DATA_W (PIX_W)
        ) u_bank (
            .clk   (clk),
            .en    (bank_en[b]),
            .we    (bank_we[b]),
            .addr  (bank_addr[b]),
            .wdata (bank_wdata),
            .rdata (bank_rdata[b])
        );
    end

    // blend pipeline
    bis_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .frac_x       (frac_x),
        .frac_y       (frac_y),
        .bank_rdata   (bank_rdata),
        .result_valid (result_valid),
        .out_blue     (out_blue),
        .out_green    (out_green),
        .out_red      (out_red),
        .inside_res   (inside_res)
    );

endmodule
